@@ hw/rtl/wcg_pkg.sv @@
// Shared constants and types for the window coefficient generator.
package wcg_pkg;

  // Window geometry and output format
  localparam int MAX_WINDOW = 4096;
  localparam int FRAC_BITS  = 15;

  // Configuration register indexes
  localparam logic [1:0] CFG_SIZE  = 2'd0;
  localparam logic [1:0] CFG_TYPE  = 2'd1;
  localparam logic [1:0] CFG_PAD   = 2'd2;
  localparam logic [1:0] CFG_ALIGN = 2'd3;

  // Window type codes
  localparam logic [2:0] WT_RECT     = 3'd0;
  localparam logic [2:0] WT_HANN     = 3'd1;
  localparam logic [2:0] WT_TRI      = 3'd2;
  localparam logic [2:0] WT_HAMMING  = 3'd3;
  localparam logic [2:0] WT_BLACKMAN = 3'd4;
  localparam logic [2:0] WT_HALFSINE = 3'd5;

  // Alignment codes
  localparam logic [1:0] AL_LEFT   = 2'd0;
  localparam logic [1:0] AL_CENTER = 2'd1;
  localparam logic [1:0] AL_RIGHT  = 2'd2;

  // Q30 constants
  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [30:0] S_A1  = 31'd1686629713;
  localparam logic [30:0] S_A3  = 31'd693598668;
  localparam logic [30:0] S_A5  = 31'd85569306;
  localparam logic [30:0] S_A7  = 31'd5026995;
  localparam logic [30:0] S_A9  = 31'd172272;
  localparam logic [30:0] S_A11 = 31'd3864;
  localparam logic [30:0] K_054 = 31'd579820585;
  localparam logic [30:0] K_046 = 31'd493921239;
  localparam logic [30:0] K_042 = 31'd450971566;
  localparam logic [30:0] K_050 = 31'd536870912;
  localparam logic [30:0] K_008 = 31'd85899346;

  // Rounding from Q30 down to the output fraction
  localparam int RND_SHIFT = 30 - FRAC_BITS;
  localparam logic [30:0] RND_HALF = 31'((1 << RND_SHIFT) >> 1);

  // Pipeline depths
  localparam int DIV_STAGES = 16;   // two quotient bits per stage
  localparam int SIN_LAT    = 9;    // sine unit register stages
  localparam int LAT        = 2 + DIV_STAGES + 1 + SIN_LAT + 2;

  // Per-item flags that travel beside the data
  typedef struct packed {
    logic act;
    logic beyond;
  } wcg_flags_t;

endpackage

@@ hw/rtl/wcg_sine.sv @@
// Pipelined Q30 sine of a 32-bit turn phase: fold, square, Horner, sign.
module wcg_sine (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] sin_o
);
  import wcg_pkg::*;

  logic [30:0] x_r   [7];
  logic        neg_r [8];
  logic [30:0] xx_r  [5];
  logic [30:0] t_r   [5];
  logic [30:0] m_r;
  logic signed [31:0] s_r;

  logic [30:0] xf;
  logic [61:0] sq;
  logic [61:0] hp [5];
  logic [61:0] fp;

  // Fold the phase into a quarter wave
  always_comb begin
    if (phase_i[30]) begin
      xf = 31'(Q30_ONE - {1'b0, phase_i[29:0]});
    end else begin
      xf = {1'b0, phase_i[29:0]};
    end
  end

  assign sq = x_r[0] * x_r[0];
  assign hp[0] = S_A11 * xx_r[0];
  assign fp = x_r[6] * t_r[4];

  // Horner products, one multiplier per stage
  always_comb begin
    for (int i = 1; i < 5; i++) begin
      hp[i] = t_r[i-1] * xx_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= xf;
      neg_r[0] <= phase_i[31];
      for (int j = 1; j < 7; j++) begin
        x_r[j] <= x_r[j-1];
      end
      for (int j = 1; j < 8; j++) begin
        neg_r[j] <= neg_r[j-1];
      end
      xx_r[0] <= sq[60:30];
      for (int j = 1; j < 5; j++) begin
        xx_r[j] <= xx_r[j-1];
      end
      t_r[0] <= 31'({1'b0, S_A9} - hp[0][61:30]);
      t_r[1] <= 31'({1'b0, S_A7} - hp[1][61:30]);
      t_r[2] <= 31'({1'b0, S_A5} - hp[2][61:30]);
      t_r[3] <= 31'({1'b0, S_A3} - hp[3][61:30]);
      t_r[4] <= 31'({1'b0, S_A1} - hp[4][61:30]);
      m_r    <= fp[60:30];
      s_r    <= neg_r[7] ? -$signed({1'b0, m_r}) : $signed({1'b0, m_r});
    end
  end

  assign sin_o = s_r;

endmodule

@@ hw/rtl/window_coefficient_generator.sv @@
// Top level: pipelined analysis-window coefficient generator.
//
// Usage:
//   Input channel in_valid/in_ready carries one sample index per transaction.
//   Output channel out_valid/out_ready returns its coefficient (unsigned
//   Q1.15), the active-part flag and the beyond-size flag.
//   Configuration channel cfg_valid/cfg_ready writes window size, type,
//   zero padding and alignment; cfg_ready is always high. Write only while
//   no transaction is in flight.
// Throughput: one index per cycle while out_ready does not stall the
//   pipeline. The pipeline includes the 16-stage two-bit-per-stage phase
//   divider and the 9-stage polynomial sine units.
// Reset: synchronous active-low rst_n empties the pipeline and loads size
//   1024, rectangular, no padding, left alignment.
// Stall: when a result waits and out_ready is low, every stage holds and
//   in_ready drops; nothing is lost or repeated.
module window_coefficient_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_sample_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_coefficient,
  output logic        out_in_active_part,
  output logic        out_index_beyond_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import wcg_pkg::*;

  logic [12:0] window_size_r;
  logic [2:0]  window_type_r;
  logic [12:0] zero_padding_r;
  logic [1:0]  window_alignment_r;

  logic        en;
  logic        vld_r [LAT];
  wcg_flags_t  fl_r  [LAT];

  logic [12:0] size;
  logic        pad_all;
  logic [12:0] active;
  logic [12:0] first;
  logic [13:0] end_pos;
  logic [11:0] den;
  logic        act;
  logic        beyond;

  logic [11:0] k_r;
  logic [43:0] n_r;
  logic [11:0] rem_r [DIV_STAGES];
  logic [31:0] low_r [DIV_STAGES];
  logic [31:0] q_r   [DIV_STAGES];
  logic [11:0] rin   [DIV_STAGES];
  logic [31:0] lin   [DIV_STAGES];
  logic [31:0] qin   [DIV_STAGES];
  logic [11:0] rout  [DIV_STAGES];
  logic [31:0] lout  [DIV_STAGES];
  logic [31:0] qout  [DIV_STAGES];

  logic [31:0] ph_a_r;
  logic [31:0] ph_b_r;
  logic [30:0] tri_d_r [SIN_LAT+1];
  logic signed [31:0] sa;
  logic signed [31:0] sb;

  logic [30:0] absa;
  logic [30:0] absb;
  logic [30:0] op_a;
  logic [61:0] mul_a;
  logic [61:0] mul_b;
  logic [30:0] pa_r;
  logic [30:0] pb_r;
  logic        sga_r;
  logic        sgb_r;
  logic signed [31:0] sa_r;
  logic [30:0] tri_c_r;

  logic signed [33:0] v;
  logic [30:0] vc;
  logic [31:0] rsum;
  logic [15:0] coef_r;

  logic signed [14:0] d2;
  logic [13:0] d2_abs;
  logic [11:0] tnum;
  logic [43:0] n_nxt;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r      <= 13'd1024;
      window_type_r      <= WT_RECT;
      zero_padding_r     <= 13'd0;
      window_alignment_r <= AL_LEFT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SIZE:  window_size_r      <= cfg_data;
        CFG_TYPE:  window_type_r      <= cfg_data[2:0];
        CFG_PAD:   zero_padding_r     <= cfg_data;
        CFG_ALIGN: window_alignment_r <= cfg_data[1:0];
        default:   window_size_r      <= window_size_r;
      endcase
    end
  end

  // Geometry derived from the static configuration
  always_comb begin
    size = ({19'b0, window_size_r} > 32'(MAX_WINDOW)) ? 13'(MAX_WINDOW) : window_size_r;
    pad_all = (zero_padding_r >= size);
    active = (zero_padding_r == 13'd0) ? size : 13'(size - zero_padding_r);
    first = 13'd0;
    if (zero_padding_r != 13'd0) begin
      priority if (window_alignment_r == AL_CENTER) begin
        first = {1'b0, zero_padding_r[12:1]};
      end else if (window_alignment_r == AL_RIGHT) begin
        first = zero_padding_r;
      end else begin
        first = 13'd0;
      end
    end
    end_pos = {1'b0, first} + {1'b0, active};
    den = (pad_all || active <= 13'd1) ? 12'd1 : 12'(active - 13'd1);
  end

  // Pipeline advances unless a finished result is held
  assign en = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;

  // Stage 1 placement checks
  assign beyond = ({1'b0, in_sample_index} >= size);
  assign act = !beyond && !pad_all && ({1'b0, in_sample_index} >= first) &&
               ({2'b0, in_sample_index} < end_pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl_r[0].act    <= act;
      fl_r[0].beyond <= beyond;
      for (int i = 1; i < LAT; i++) begin
        fl_r[i] <= fl_r[i-1];
      end
      k_r <= act ? 12'({1'b0, in_sample_index} - first) : 12'd0;
    end
  end

  // Stage 2 dividend: phase or triangle numerator, pre-rounded
  always_comb begin
    d2 = $signed({2'b0, k_r, 1'b0}) - $signed({3'b0, den});
    d2_abs = d2[14] ? 14'(-d2) : 14'(d2);
    tnum = 12'({3'b0, den} - {1'b0, d2_abs});
    if (window_type_r == WT_TRI) begin
      n_nxt = {2'b0, tnum, 30'b0} + {33'b0, den[11:1]};
    end else begin
      n_nxt = {1'b0, k_r, 31'b0} + {33'b0, den[11:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_nxt;
    end
  end

  // Restoring divider, two quotient bits per stage
  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        rin[s] = n_r[43:32];
        lin[s] = n_r[31:0];
        qin[s] = 32'd0;
      end else begin
        rin[s] = rem_r[s-1];
        lin[s] = low_r[s-1];
        qin[s] = q_r[s-1];
      end
    end
  end

  always_comb begin
    logic [12:0] rs;
    logic [11:0] r;
    logic [31:0] l;
    logic [31:0] q;
    logic        ge;
    for (int s = 0; s < DIV_STAGES; s++) begin
      r = rin[s];
      l = lin[s];
      q = qin[s];
      for (int b = 0; b < 2; b++) begin
        rs = {r, l[31]};
        ge = (rs >= {1'b0, den});
        r = ge ? 12'(rs - {1'b0, den}) : rs[11:0];
        l = {l[30:0], 1'b0};
        q = {q[30:0], ge};
      end
      rout[s] = r;
      lout[s] = l;
      qout[s] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_r[s] <= rout[s];
        low_r[s] <= lout[s];
        q_r[s]   <= qout[s];
      end
    end
  end

  // Phase stage: pick sine or cosine angles
  always_ff @(posedge clk) begin
    if (en) begin
      if (window_type_r == WT_HAMMING || window_type_r == WT_BLACKMAN) begin
        ph_a_r <= {q_r[DIV_STAGES-1][30:0], 1'b0} + 32'h4000_0000;
      end else begin
        ph_a_r <= q_r[DIV_STAGES-1];
      end
      ph_b_r <= {q_r[DIV_STAGES-1][29:0], 2'b0} + 32'h4000_0000;
      tri_d_r[0] <= q_r[DIV_STAGES-1][30:0];
      for (int i = 1; i <= SIN_LAT; i++) begin
        tri_d_r[i] <= tri_d_r[i-1];
      end
    end
  end

  wcg_sine u_sine_a (
    .clk     (clk),
    .en      (en),
    .phase_i (ph_a_r),
    .sin_o   (sa)
  );

  wcg_sine u_sine_b (
    .clk     (clk),
    .en      (en),
    .phase_i (ph_b_r),
    .sin_o   (sb)
  );

  // Combine stage 1: weight products
  always_comb begin
    absa = sa[31] ? 31'(-sa) : 31'(sa);
    absb = sb[31] ? 31'(-sb) : 31'(sb);
    unique case (window_type_r)
      WT_HANN:    op_a = absa;
      WT_HAMMING: op_a = K_046;
      default:    op_a = K_050;
    endcase
  end

  assign mul_a = absa * op_a;
  assign mul_b = absb * K_008;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r    <= mul_a[60:30];
      pb_r    <= mul_b[60:30];
      sga_r   <= sa[31];
      sgb_r   <= sb[31];
      sa_r    <= sa;
      tri_c_r <= tri_d_r[SIN_LAT];
    end
  end

  // Combine stage 2: window sum, clamp and round
  always_comb begin
    logic signed [33:0] pas;
    logic signed [33:0] pbs;
    pas = sga_r ? -$signed({3'b0, pa_r}) : $signed({3'b0, pa_r});
    pbs = sgb_r ? -$signed({3'b0, pb_r}) : $signed({3'b0, pb_r});
    unique case (window_type_r)
      WT_RECT:     v = $signed({3'b0, Q30_ONE});
      WT_HANN:     v = $signed({3'b0, pa_r});
      WT_TRI:      v = $signed({3'b0, tri_c_r});
      WT_HAMMING:  v = $signed({3'b0, K_054}) - pas;
      WT_BLACKMAN: v = $signed({3'b0, K_042}) - pas + pbs;
      WT_HALFSINE: v = 34'(sa_r);
      default:     v = 34'sd0;
    endcase
    if (v < 34'sd0) begin
      vc = 31'd0;
    end else if (v > $signed({3'b0, Q30_ONE})) begin
      vc = Q30_ONE;
    end else begin
      vc = v[30:0];
    end
    rsum = {1'b0, vc} + {1'b0, RND_HALF};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coef_r <= 16'(rsum >> RND_SHIFT);
    end
  end

  assign out_valid             = vld_r[LAT-1];
  assign out_in_active_part    = fl_r[LAT-1].act;
  assign out_index_beyond_size = fl_r[LAT-1].beyond;
  assign out_coefficient       = fl_r[LAT-1].act ? coef_r : 16'd0;

`ifndef NO_ASSERTIONS
  // Beyond-size items never report an active position
  a_beyond_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_beyond_size |-> !out_in_active_part)
    else $error("beyond-size result flagged active");

  // Rectangular window gives exactly one in the active part
  a_rect_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_active_part && window_type_r == WT_RECT
    |-> out_coefficient == 16'(1 << FRAC_BITS))
    else $error("rectangular coefficient not unity");

  // Coefficient never exceeds one
  a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_coefficient <= 16'(1 << FRAC_BITS))
    else $error("coefficient above one");

  // A held result keeps the input side stalled
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");
`endif

endmodule
